// ----- hdl/prim64_pkg.sv -----
// ----------------------------------------------------------------------------
// prim64_pkg
// Shared widths, base table and the request/response types of the modular
// multiplier.
// ----------------------------------------------------------------------------
package prim64_pkg;

	localparam int unsigned CAND_W    = 63;
	localparam int unsigned CNT_W     = 6;
	localparam int unsigned NUM_TAB   = 12;
	localparam int unsigned NUM_BASES = 12;
	localparam int unsigned IDX_W     = $clog2(NUM_TAB);
	localparam int unsigned BASE_W    = 6;
	localparam logic [CAND_W-1:0] SMALL_LIMIT = CAND_W'(40);

	typedef logic [CAND_W-1:0] cand_t;

	// full table; the first NUM_BASES entries are used
	typedef logic [BASE_W-1:0] base_tab_t [NUM_TAB];
	localparam base_tab_t BASES = '{
		6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
		6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
	};

	function automatic cand_t base_at(input logic [IDX_W-1:0] idx);
		return {{(CAND_W-BASE_W){1'b0}}, BASES[idx]};
	endfunction

	// a must be below m; only the bits of b are used
	typedef struct packed {
		logic  start;
		cand_t a;
		cand_t b;
		cand_t m;
	} mm_req_t;

	typedef struct packed {
		logic  done;
		cand_t prod;
	} mm_rsp_t;

endpackage

// ----- hdl/prim64_if.sv -----
// ----------------------------------------------------------------------------
// prim64 channels
// Valid/ready channels for the candidate word and the verdict word.
// ----------------------------------------------------------------------------
interface prim64_cand_if;
	logic                  valid;
	logic                  ready;
	prim64_pkg::cand_t     candidate;
	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface

interface prim64_res_if;
	logic valid;
	logic ready;
	logic is_prime;
	modport source (output valid, output is_prime, input ready);
	modport sink   (input valid, input is_prime, output ready);
endinterface

// ----- hdl/prim64_modmul.sv -----
// ----------------------------------------------------------------------------
// prim64_modmul
// Bit-serial (a * b) mod m, one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module prim64_modmul (
	input  logic                clk,
	input  logic                arst_n,
	input  prim64_pkg::mm_req_t req,
	output prim64_pkg::mm_rsp_t rsp
);

	localparam int unsigned W = prim64_pkg::CAND_W;

	prim64_pkg::cand_t acc_q, a_q, b_q, m_q;
	logic [prim64_pkg::CNT_W-1:0] cnt_q;
	logic busy_q, done_q;

	logic [W+1:0] t, m1, m2;
	logic [W+1:0] nxt;
	logic [W-1:0] a_sel;

	always_comb begin
		a_sel = b_q[cnt_q] ? a_q : '0;
		t     = {1'b0, acc_q, 1'b0} + {2'b00, a_sel};
		m1    = {2'b00, m_q};
		m2    = {1'b0, m_q, 1'b0};
		if (t >= m2) begin
			nxt = t - m2;
		end else if (t >= m1) begin
			nxt = t - m1;
		end else begin
			nxt = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q   <= req.a;
			b_q   <= req.b;
			m_q   <= req.m;
			cnt_q <= prim64_pkg::CNT_W'(W - 1);
		end else if (busy_q) begin
			acc_q <= nxt[W-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

// ----- hdl/primality_test_64bit_unit.sv -----
// Candidates up to 40 get their verdict without modular products; larger ones
// take up to ~125 modular products per base over 12 bases.
// Throughput: one word at a time; the single shared modular multiplier sets it.
// A new word is taken as soon as the previous verdict is loaded for output.
// Reset: arst_n asynchronously clears sequencer and output valid.
// ----------------------------------------------------------------------------
// primality_test_64bit_unit
// Miller-Rabin over bases 2..37 driven by a sequencer around one modmul.
// ----------------------------------------------------------------------------
module primality_test_64bit_unit (
	input  logic                clk,
	input  logic                arst_n,
	prim64_cand_if.sink         cand,
	prim64_res_if.source        res
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLASS = 4'd1;
	localparam logic [3:0] ST_TWOS  = 4'd2;
	localparam logic [3:0] ST_DIV   = 4'd3;
	localparam logic [3:0] ST_DIVW  = 4'd4;
	localparam logic [3:0] ST_PCHK  = 4'd5;
	localparam logic [3:0] ST_PMUL  = 4'd6;
	localparam logic [3:0] ST_PMULW = 4'd7;
	localparam logic [3:0] ST_PSQ   = 4'd8;
	localparam logic [3:0] ST_PSQW  = 4'd9;
	localparam logic [3:0] ST_CHK   = 4'd10;
	localparam logic [3:0] ST_SLOOP = 4'd11;
	localparam logic [3:0] ST_SQR   = 4'd12;
	localparam logic [3:0] ST_SQRW  = 4'd13;
	localparam logic [3:0] ST_NEXT  = 4'd14;
	localparam logic [3:0] ST_DONE  = 4'd15;

	localparam int unsigned W = prim64_pkg::CAND_W;

	logic [3:0] state_q;
	prim64_pkg::cand_t n_q, d_q, e_q, res_q, sq_q;
	logic [prim64_pkg::CNT_W-1:0] twos_q, r_q;
	logic [prim64_pkg::IDX_W-1:0] idx_q;
	logic verdict_q, out_valid_q, out_bit_q;

	prim64_pkg::mm_req_t mm_req;
	prim64_pkg::mm_rsp_t mm_rsp;
	prim64_pkg::cand_t   n_m1, base;
	logic                is_base;
	logic                out_load;

	prim64_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mm_req),
		.rsp    (mm_rsp)
	);

	assign n_m1 = n_q - W'(1);
	assign base = prim64_pkg::base_at(idx_q);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || res.ready);

	always_comb begin
		is_base = 1'b0;
		for (int i = 0; i < prim64_pkg::NUM_BASES; i++) begin
			if (n_q == prim64_pkg::base_at(prim64_pkg::IDX_W'(i))) begin
				is_base = 1'b1;
			end
		end
	end

	always_comb begin
		mm_req.start = 1'b0;
		mm_req.a     = res_q;
		mm_req.b     = sq_q;
		mm_req.m     = n_q;
		unique case (state_q)
			ST_DIV: begin
				mm_req.start = 1'b1;
				mm_req.a     = W'(1);
				mm_req.b     = n_q;
				mm_req.m     = base;
			end
			ST_PMUL: begin
				mm_req.start = 1'b1;
			end
			ST_PSQ: begin
				mm_req.start = 1'b1;
				mm_req.a     = sq_q;
			end
			ST_SQR: begin
				mm_req.start = 1'b1;
				mm_req.b     = res_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !res.ready);
			unique case (state_q)
				ST_IDLE: if (cand.valid) begin
					state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					if (is_base || n_q <= prim64_pkg::SMALL_LIMIT) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_TWOS;
					end
				end
				ST_TWOS: if (d_q[0]) begin
					state_q <= ST_DIV;
				end
				ST_DIV:   state_q <= ST_DIVW;
				ST_DIVW: if (mm_rsp.done) begin
					state_q <= (mm_rsp.prod == '0) ? ST_DONE : ST_PCHK;
				end
				ST_PCHK: begin
					if (e_q == '0) begin
						state_q <= ST_CHK;
					end else if (e_q[0]) begin
						state_q <= ST_PMUL;
					end else begin
						state_q <= ST_PSQ;
					end
				end
				ST_PMUL:  state_q <= ST_PMULW;
				ST_PMULW: if (mm_rsp.done) begin
					state_q <= ST_PSQ;
				end
				ST_PSQ:   state_q <= ST_PSQW;
				ST_PSQW: if (mm_rsp.done) begin
					state_q <= ST_PCHK;
				end
				ST_CHK: begin
					state_q <= (res_q == W'(1) || res_q == n_m1) ? ST_NEXT : ST_SLOOP;
				end
				ST_SLOOP: state_q <= (r_q >= twos_q) ? ST_DONE : ST_SQR;
				ST_SQR:   state_q <= ST_SQRW;
				ST_SQRW: if (mm_rsp.done) begin
					state_q <= (mm_rsp.prod == n_m1) ? ST_NEXT : ST_SLOOP;
				end
				ST_NEXT: begin
					state_q <= (idx_q == prim64_pkg::IDX_W'(prim64_pkg::NUM_BASES - 1))
						? ST_DONE : ST_DIV;
				end
				ST_DONE: if (out_load) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (cand.valid) begin
				n_q <= cand.candidate;
			end
			ST_CLASS: begin
				verdict_q <= is_base;
				d_q       <= n_m1;
				twos_q    <= '0;
				idx_q     <= '0;
			end
			ST_TWOS: if (!d_q[0]) begin
				d_q    <= d_q >> 1;
				twos_q <= twos_q + 1'b1;
			end
			ST_DIVW: if (mm_rsp.done) begin
				verdict_q <= 1'b0;
				res_q     <= W'(1);
				sq_q      <= base;
				e_q       <= d_q;
			end
			ST_PMULW: if (mm_rsp.done) begin
				res_q <= mm_rsp.prod;
			end
			ST_PSQW: if (mm_rsp.done) begin
				sq_q <= mm_rsp.prod;
				e_q  <= e_q >> 1;
			end
			ST_CHK: r_q <= prim64_pkg::CNT_W'(1);
			ST_SQRW: if (mm_rsp.done) begin
				res_q <= mm_rsp.prod;
				r_q   <= r_q + 1'b1;
			end
			ST_NEXT: begin
				idx_q     <= idx_q + 1'b1;
				verdict_q <= 1'b1;
			end
			ST_DONE: if (out_load) begin
				out_bit_q <= verdict_q;
			end
			default: begin
			end
		endcase
	end

	assign cand.ready   = (state_q == ST_IDLE);
	assign res.valid    = out_valid_q;
	assign res.is_prime = out_bit_q;

endmodule

// ----- sim/prim64_tb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prim64 testbench channels
// The testbench uses the channel interfaces of the design as they are; this
// file only holds the word type that the stimulus queue carries.
// ----------------------------------------------------------------------------
package prim64_tb_pkg;

	import prim64_pkg::*;

	// drain: hold the word until every expected verdict has come back
	typedef struct {
		cand_t value;
		bit    drain;
	} cand_word_t;

endpackage

// ----- sim/tb_primality_test_64bit_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_primality_test_64bit_unit
// Checks the Miller-Rabin unit word by word against a behavioral predictor:
// directed edge values, known pseudoprimes and large primes, then random
// words, with random gaps on both channels, one long output stall and one
// full drain of the pipeline.
// ----------------------------------------------------------------------------
module tb_primality_test_64bit_unit;

	import prim64_pkg::*;
	import prim64_tb_pkg::*;

	localparam int unsigned STALL_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;

	prim64_cand_if cand_ch ();
	prim64_res_if  res_ch ();

	primality_test_64bit_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand_ch),
		.res    (res_ch)
	);

	cand_word_t pending_words[$];
	bit         verdicts_due[$];
	int         n_errors = 0;
	int         n_checked = 0;
	int         n_primes = 0;
	int         n_sent = 0;
	bit         stim_done = 0;
	bit         cand_taken = 0;
	int unsigned idle_cycles = 0;

	// --- predictor ---------------------------------------------------------
	function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
	                                       logic [63:0] m);
		logic [63:0] acc;
		acc = 0;
		a = a % m;
		b = b % m;
		for (int i = 62; i >= 0; i--) begin
			acc = acc + acc;
			if (acc >= m) acc = acc - m;
			if (b[i]) begin
				acc = acc + a;
				if (acc >= m) acc = acc - m;
			end
		end
		return acc;
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e,
	                                       logic [63:0] m);
		logic [63:0] r;
		logic [63:0] sq;
		r = 1;
		sq = b % m;
		while (e != 0) begin
			if (e[0]) r = mulmod(r, sq, m);
			sq = mulmod(sq, sq, m);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic bit base_proves_composite(logic [63:0] n, logic [63:0] a);
		logic [63:0] d;
		logic [63:0] x;
		int          s;
		if (n % a == 0) return 1;
		d = n - 1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		x = powmod(a, d, n);
		if (x == 1 || x == n - 1) return 0;
		for (int r = 1; r < s; r++) begin
			x = mulmod(x, x, n);
			if (x == n - 1) return 0;
		end
		return 1;
	endfunction

	function automatic bit primality_of(cand_t c);
		logic [63:0] n;
		n = {1'b0, c};
		for (int i = 0; i < NUM_BASES; i++)
			if (n == 64'(BASES[i])) return 1;
		if (n <= 64'(SMALL_LIMIT)) return 0;
		for (int i = 0; i < NUM_BASES; i++)
			if (base_proves_composite(n, 64'(BASES[i]))) return 0;
		return 1;
	endfunction

	task automatic report_mismatch(string msg);
		n_errors++;
		$display("[%0t] MISMATCH %s", $realtime, msg);
	endtask

	task automatic queue_word(cand_t v, bit drain = 0);
		cand_word_t w;
		w.value = v;
		w.drain = drain;
		pending_words.insert(pending_words.size(), w);
	endtask

	// --- clock and reset ---------------------------------------------------
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// --- stimulus ----------------------------------------------------------
	initial begin
		cand_t r;
		for (int i = 0; i < NUM_BASES; i++) queue_word(cand_t'(BASES[i]));
		queue_word(cand_t'(0));
		queue_word(cand_t'(1));
		queue_word(cand_t'(4));
		queue_word(cand_t'(39));
		queue_word(cand_t'(40));
		queue_word(cand_t'(41));
		queue_word(cand_t'(49));
		queue_word(cand_t'(561));
		queue_word(63'd3215031751);
		queue_word(63'd3825123056546413051);
		queue_word(63'd2305843009213693951);
		queue_word(63'd9223372036854775783);
		queue_word({CAND_W{1'b1}});
		for (int i = 0; i < 75; i++) begin
			int sel;
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				r = cand_t'($urandom_range(41, 4095)) | 63'd1;
			end else begin
				r = cand_t'({$urandom(), $urandom()});
				if (sel < 9) r[0] = 1'b1;
			end
			queue_word(r, i == 40);
		end
		stim_done = 1;
	end

	// --- driver ------------------------------------------------------------
	always @(posedge clk) begin
		cand_taken <= arst_n && cand_ch.valid && cand_ch.ready;
		if (arst_n && cand_ch.valid && cand_ch.ready) begin
			verdicts_due.insert(verdicts_due.size(), primality_of(cand_ch.candidate));
			n_sent++;
		end
	end

	int cand_gap = 0;
	initial begin
		cand_ch.valid = 0;
		cand_ch.candidate = '0;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (cand_taken) begin
				cand_ch.valid <= 0;
				cand_gap = $urandom_range(0, 5);
			end else if (!cand_ch.valid) begin
				if (cand_gap > 0) begin
					cand_gap--;
				end else if (pending_words.size() > 0 &&
				             (!pending_words[0].drain || verdicts_due.size() == 0)) begin
					cand_word_t w;
					w = pending_words.pop_front();
					cand_ch.candidate <= w.value;
					cand_ch.valid <= 1;
				end
			end
		end
	end

	// --- monitor -----------------------------------------------------------
	bit res_taken = 0;
	always @(posedge clk) begin
		res_taken <= arst_n && res_ch.valid && res_ch.ready;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch($sformatf("unexpected verdict %0d", res_ch.is_prime));
			end else begin
				bit want;
				want = verdicts_due.pop_front();
				if (res_ch.is_prime !== want)
					report_mismatch($sformatf("is_prime: got %0d, expected %0d",
					                          res_ch.is_prime, want));
				n_primes += want;
			end
			n_checked++;
		end
	end

	int  res_gap = 0;
	bit  held = 0;
	initial res_ch.ready = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				res_ch.ready <= 0;
				if (!held && n_checked == 3) begin
					held = 1;
					res_gap = HOLD_CYCLES;
				end else begin
					res_gap = $urandom_range(0, 5);
				end
			end else if (res_gap > 0) begin
				res_gap--;
			end else begin
				res_ch.ready <= 1;
			end
		end
	end

	// --- watchdog and end of run ------------------------------------------
	always @(posedge clk) begin
		if ((cand_ch.valid && cand_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d idle cycles", idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_words.size() == 0 && !cand_ch.valid && verdicts_due.size() == 0);
		repeat (200) @(posedge clk);
		$display("Covered %0d words (%0d prime): edge values, pseudoprimes, large primes,",
		         n_sent, n_primes);
		$display("random words, a long output stall and a full drain; %0d errors", n_errors);
		if (n_errors == 0 && verdicts_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- primality_test_64bit_unit.f -----
hdl/prim64_pkg.sv
hdl/prim64_if.sv
hdl/prim64_modmul.sv
hdl/primality_test_64bit_unit.sv
sim/prim64_tb_if.sv
sim/tb_primality_test_64bit_unit.sv
